// ===== hw/rtl/dgsp_pkg.sv =====
// dgsp_pkg: shared constants, command codes and memory request structs
// for the dense graph shortest path block; no dependencies
package dgsp_pkg;

    localparam int MAX_VERTICES  = 64;
    localparam int VIDX_BITS     = $clog2(MAX_VERTICES);
    localparam int COUNT_BITS    = $clog2(MAX_VERTICES + 1);
    localparam int ADJ_ADDR_BITS = 2 * VIDX_BITS;
    localparam int WEIGHT_BITS   = 16;
    localparam int DIST_BITS     = 24;
    localparam int CMD_BITS      = 2;
    localparam int CFG_BITS      = 7;

    localparam logic [DIST_BITS-1:0] DIST_MAX = {DIST_BITS{1'b1}};
    localparam logic [CFG_BITS-1:0]  VCOUNT_RESET = CFG_BITS'(MAX_VERTICES);

    localparam logic [CMD_BITS-1:0] CMD_CLEAR = 2'd0;
    localparam logic [CMD_BITS-1:0] CMD_ADD   = 2'd1;
    localparam logic [CMD_BITS-1:0] CMD_RUN   = 2'd2;

    typedef struct packed {
        logic                     we;
        logic [ADJ_ADDR_BITS-1:0] waddr;
        logic [WEIGHT_BITS-1:0]   wdata;
        logic [ADJ_ADDR_BITS-1:0] raddr;
    } adj_req_t;

    typedef struct packed {
        logic                 we;
        logic [VIDX_BITS-1:0] waddr;
        logic [DIST_BITS-1:0] wdata;
        logic [VIDX_BITS-1:0] raddr;
    } dist_req_t;

endpackage

// ===== hw/rtl/dgsp_if.sv =====
// dgsp interfaces: command, result and setup channels with valid/ready
// depends on dgsp_pkg
interface dgsp_item_if;
    import dgsp_pkg::*;
    logic                   valid;
    logic                   ready;
    logic [CMD_BITS-1:0]    cmd;
    logic [VIDX_BITS-1:0]   vertex_a;
    logic [VIDX_BITS-1:0]   vertex_b;
    logic [WEIGHT_BITS-1:0] edge_weight;
    modport source (output valid, cmd, vertex_a, vertex_b, edge_weight, input ready);
    modport sink (input valid, cmd, vertex_a, vertex_b, edge_weight, output ready);
endinterface

interface dgsp_result_if;
    import dgsp_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [VIDX_BITS-1:0] vertex_id;
    logic [DIST_BITS-1:0] distance;
    logic                 reachable;
    logic                 last_result;
    modport source (output valid, vertex_id, distance, reachable, last_result, input ready);
    modport sink (input valid, vertex_id, distance, reachable, last_result, output ready);
endinterface

interface dgsp_setup_if;
    import dgsp_pkg::*;
    logic                valid;
    logic                ready;
    logic [CFG_BITS-1:0] data;
    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

// ===== hw/rtl/dense_graph_shortest_paths.sv =====
// dense_graph_shortest_paths: shortest paths from vertex 0 over an adjacency matrix
// operations: a clear sweeps the matrix, an add writes the edge and its mirror, and a
// search with n vertices runs up to n-1 scan and relax rounds at one read per cycle, then emits
// handshake: next transaction taken once the previous one is done; results leave one
// at a time through an output register, the next read only once that register is free
// reset: asynchronous, then a clearing pass over the whole matrix memory
// depends on dgsp_pkg, dgsp_if, dgsp_ram and dgsp_ctrl
module dense_graph_shortest_paths (
    input  logic          clk,
    input  logic          rst_n,
    dgsp_item_if.sink     item,
    dgsp_result_if.source result,
    dgsp_setup_if.sink    setup
);
    import dgsp_pkg::*;

    adj_req_t               adj_req;
    dist_req_t              dist_req;
    logic [WEIGHT_BITS-1:0] adj_rdata;
    logic [DIST_BITS-1:0]   dist_rdata;

    dgsp_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item),
        .result     (result),
        .setup      (setup),
        .adj_req    (adj_req),
        .dist_req   (dist_req),
        .adj_rdata  (adj_rdata),
        .dist_rdata (dist_rdata)
    );

    dgsp_ram #(
        .ADDR_BITS (ADJ_ADDR_BITS),
        .DATA_BITS (WEIGHT_BITS)
    ) u_adj_ram (
        .clk   (clk),
        .we    (adj_req.we),
        .waddr (adj_req.waddr),
        .wdata (adj_req.wdata),
        .raddr (adj_req.raddr),
        .rdata (adj_rdata)
    );

    dgsp_ram #(
        .ADDR_BITS (VIDX_BITS),
        .DATA_BITS (DIST_BITS)
    ) u_dist_ram (
        .clk   (clk),
        .we    (dist_req.we),
        .waddr (dist_req.waddr),
        .wdata (dist_req.wdata),
        .raddr (dist_req.raddr),
        .rdata (dist_rdata)
    );

    a_idle_no_dist_write: assert property (@(posedge clk) disable iff (!rst_n)
        item.ready |-> !dist_req.we)
        else $error("distance write while idle");

    a_add_writes_matrix: assert property (@(posedge clk) disable iff (!rst_n)
        item.valid && item.ready && item.cmd == CMD_ADD |-> adj_req.we)
        else $error("edge add without matrix write");

    a_unreached_is_max: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && !result.reachable |-> result.distance == DIST_MAX)
        else $error("unreachable vertex with finite distance");

    a_source_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.vertex_id == '0 |-> result.reachable && result.distance == '0)
        else $error("source vertex not at distance zero");

endmodule

// ===== hw/rtl/dgsp_ram.sv =====
// dgsp_ram: generic simple dual-port ram, one write and one registered read
// no dependencies
module dgsp_ram #(
    parameter int ADDR_BITS = 6,
    parameter int DATA_BITS = 24
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [ADDR_BITS-1:0] waddr,
    input  logic [DATA_BITS-1:0] wdata,
    input  logic [ADDR_BITS-1:0] raddr,
    output logic [DATA_BITS-1:0] rdata
);

    logic [DATA_BITS-1:0] mem [2**ADDR_BITS];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hw/rtl/dgsp_ctrl.sv =====
// dgsp_ctrl: command sequencer, clearing sweep, min scan, relaxation and emission
// depends on dgsp_pkg and the dgsp interfaces
module dgsp_ctrl (
    input  logic                           clk,
    input  logic                           rst_n,
    dgsp_item_if.sink                      item,
    dgsp_result_if.source                  result,
    dgsp_setup_if.sink                     setup,
    output dgsp_pkg::adj_req_t             adj_req,
    output dgsp_pkg::dist_req_t            dist_req,
    input  logic [dgsp_pkg::WEIGHT_BITS-1:0] adj_rdata,
    input  logic [dgsp_pkg::DIST_BITS-1:0]   dist_rdata
);
    import dgsp_pkg::*;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ADD,
        ST_INIT,
        ST_SCAN,
        ST_RELAX,
        ST_EMIT
    } state_t;

    state_t                   state_reg, state_next;
    logic [ADJ_ADDR_BITS-1:0] cnt_reg, cnt_next;
    logic [COUNT_BITS-1:0]    idx_reg, idx_next;
    logic [COUNT_BITS-1:0]    round_reg, round_next;
    logic                     pend_reg, pend_next;
    logic [VIDX_BITS-1:0]     pidx_reg, pidx_next;
    logic                     found_reg, found_next;
    logic [VIDX_BITS-1:0]     best_idx_reg, best_idx_next;
    logic [DIST_BITS-1:0]     best_val_reg, best_val_next;
    logic [VIDX_BITS-1:0]     u_reg, u_next;
    logic [DIST_BITS-1:0]     du_reg, du_next;
    logic [MAX_VERTICES-1:0]  done_reg, done_next;
    logic [MAX_VERTICES-1:0]  reached_reg, reached_next;
    logic [CFG_BITS-1:0]      vcount_reg, vcount_next;
    logic [VIDX_BITS-1:0]     a_reg, a_next;
    logic [VIDX_BITS-1:0]     b_reg, b_next;
    logic [WEIGHT_BITS-1:0]   w_reg, w_next;
    logic                     out_valid_reg, out_valid_next;
    logic [VIDX_BITS-1:0]     out_id_reg, out_id_next;
    logic [DIST_BITS-1:0]     out_dist_reg, out_dist_next;
    logic                     out_reach_reg, out_reach_next;
    logic                     out_last_reg, out_last_next;

    logic [COUNT_BITS-1:0]    n_act;
    logic [COUNT_BITS-1:0]    n_last;
    logic [COUNT_BITS:0]      round_plus2;
    logic [DIST_BITS:0]       cand_sum;
    logic [DIST_BITS-1:0]     cand;
    logic                     issue_ok;

    // clamp of the vertex count register
    always_comb
    begin
        if (vcount_reg < CFG_BITS'(2))
        begin
            n_act = COUNT_BITS'(2);
        end
        else if (vcount_reg > CFG_BITS'(MAX_VERTICES))
        begin
            n_act = COUNT_BITS'(MAX_VERTICES);
        end
        else
        begin
            n_act = COUNT_BITS'(vcount_reg);
        end
    end

    assign n_last      = n_act - COUNT_BITS'(1);
    assign round_plus2 = {1'b0, round_reg} + (COUNT_BITS + 1)'(2);
    assign cand_sum    = {1'b0, du_reg} + (DIST_BITS + 1)'(adj_rdata);
    assign cand        = cand_sum[DIST_BITS] ? DIST_MAX : cand_sum[DIST_BITS-1:0];
    assign issue_ok    = (idx_reg < n_act);

    assign item.ready         = (state_reg == ST_IDLE);
    assign setup.ready        = 1'b1;
    assign result.valid       = out_valid_reg;
    assign result.vertex_id   = out_id_reg;
    assign result.distance    = out_dist_reg;
    assign result.reachable   = out_reach_reg;
    assign result.last_result = out_last_reg;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        idx_next       = idx_reg;
        round_next     = round_reg;
        pend_next      = 1'b0;
        pidx_next      = pidx_reg;
        found_next     = found_reg;
        best_idx_next  = best_idx_reg;
        best_val_next  = best_val_reg;
        u_next         = u_reg;
        du_next        = du_reg;
        done_next      = done_reg;
        reached_next   = reached_reg;
        vcount_next    = vcount_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        w_next         = w_reg;
        out_valid_next = out_valid_reg && !result.ready;
        out_id_next    = out_id_reg;
        out_dist_next  = out_dist_reg;
        out_reach_next = out_reach_reg;
        out_last_next  = out_last_reg;

        adj_req.we     = 1'b0;
        adj_req.waddr  = {a_reg, b_reg};
        adj_req.wdata  = w_reg;
        adj_req.raddr  = {u_reg, idx_reg[VIDX_BITS-1:0]};
        dist_req.we    = 1'b0;
        dist_req.waddr = pidx_reg;
        dist_req.wdata = cand;
        dist_req.raddr = idx_reg[VIDX_BITS-1:0];

        if (setup.valid)
        begin
            vcount_next = setup.data;
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                adj_req.we    = 1'b1;
                adj_req.waddr = cnt_reg;
                adj_req.wdata = '0;
                cnt_next      = cnt_reg + ADJ_ADDR_BITS'(1);
                if (cnt_reg == {ADJ_ADDR_BITS{1'b1}})
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (item.valid)
                begin
                    case (item.cmd)
                        CMD_CLEAR:
                        begin
                            cnt_next   = '0;
                            state_next = ST_CLEAR;
                        end
                        CMD_ADD:
                        begin
                            adj_req.we    = 1'b1;
                            adj_req.waddr = {item.vertex_a, item.vertex_b};
                            adj_req.wdata = item.edge_weight;
                            a_next        = item.vertex_a;
                            b_next        = item.vertex_b;
                            w_next        = item.edge_weight;
                            state_next    = ST_ADD;
                        end
                        CMD_RUN:
                        begin
                            state_next = ST_INIT;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_ADD:
            begin
                // mirrored entry
                adj_req.we    = 1'b1;
                adj_req.waddr = {b_reg, a_reg};
                state_next    = ST_IDLE;
            end
            ST_INIT:
            begin
                done_next      = '0;
                reached_next   = {{(MAX_VERTICES-1){1'b0}}, 1'b1};
                dist_req.we    = 1'b1;
                dist_req.waddr = '0;
                dist_req.wdata = '0;
                idx_next       = '0;
                round_next     = '0;
                found_next     = 1'b0;
                state_next     = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (issue_ok)
                begin
                    pend_next = 1'b1;
                    pidx_next = idx_reg[VIDX_BITS-1:0];
                    idx_next  = idx_reg + COUNT_BITS'(1);
                end
                if (pend_reg && !done_reg[pidx_reg] && reached_reg[pidx_reg]
                    && (!found_reg || dist_rdata < best_val_reg))
                begin
                    found_next    = 1'b1;
                    best_idx_next = pidx_reg;
                    best_val_next = dist_rdata;
                end
                if (!issue_ok && !pend_reg)
                begin
                    idx_next = '0;
                    if (found_reg)
                    begin
                        done_next[best_idx_reg] = 1'b1;
                        u_next                  = best_idx_reg;
                        du_next                 = best_val_reg;
                        state_next              = ST_RELAX;
                    end
                    else
                    begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_RELAX:
            begin
                if (issue_ok)
                begin
                    pend_next = 1'b1;
                    pidx_next = idx_reg[VIDX_BITS-1:0];
                    idx_next  = idx_reg + COUNT_BITS'(1);
                end
                if (pend_reg && !done_reg[pidx_reg] && adj_rdata != '0
                    && (!reached_reg[pidx_reg] || cand < dist_rdata))
                begin
                    dist_req.we            = 1'b1;
                    reached_next[pidx_reg] = 1'b1;
                end
                if (!issue_ok && !pend_reg)
                begin
                    idx_next = '0;
                    if (round_plus2 < {1'b0, n_act})
                    begin
                        round_next = round_reg + COUNT_BITS'(1);
                        found_next = 1'b0;
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_EMIT:
            begin
                if (issue_ok && !pend_reg && (!out_valid_reg || result.ready))
                begin
                    pend_next = 1'b1;
                    pidx_next = idx_reg[VIDX_BITS-1:0];
                    idx_next  = idx_reg + COUNT_BITS'(1);
                end
                if (pend_reg)
                begin
                    out_valid_next = 1'b1;
                    out_id_next    = pidx_reg;
                    out_reach_next = reached_reg[pidx_reg];
                    out_dist_next  = reached_reg[pidx_reg] ? dist_rdata : DIST_MAX;
                    out_last_next  = (COUNT_BITS'(pidx_reg) == n_last);
                    if (COUNT_BITS'(pidx_reg) == n_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            cnt_reg       <= '0;
            idx_reg       <= '0;
            round_reg     <= '0;
            pend_reg      <= 1'b0;
            pidx_reg      <= '0;
            found_reg     <= 1'b0;
            best_idx_reg  <= '0;
            best_val_reg  <= '0;
            u_reg         <= '0;
            du_reg        <= '0;
            done_reg      <= '0;
            reached_reg   <= '0;
            vcount_reg    <= VCOUNT_RESET;
            a_reg         <= '0;
            b_reg         <= '0;
            w_reg         <= '0;
            out_valid_reg <= 1'b0;
            out_id_reg    <= '0;
            out_dist_reg  <= '0;
            out_reach_reg <= 1'b0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            idx_reg       <= idx_next;
            round_reg     <= round_next;
            pend_reg      <= pend_next;
            pidx_reg      <= pidx_next;
            found_reg     <= found_next;
            best_idx_reg  <= best_idx_next;
            best_val_reg  <= best_val_next;
            u_reg         <= u_next;
            du_reg        <= du_next;
            done_reg      <= done_next;
            reached_reg   <= reached_next;
            vcount_reg    <= vcount_next;
            a_reg         <= a_next;
            b_reg         <= b_next;
            w_reg         <= w_next;
            out_valid_reg <= out_valid_next;
            out_id_reg    <= out_id_next;
            out_dist_reg  <= out_dist_next;
            out_reach_reg <= out_reach_next;
            out_last_reg  <= out_last_next;
        end
    end

endmodule
